// ===== src/gbcd_pkg.sv =====
package gbcd_pkg;

	localparam int GRID_WIDTH_DEF  = 64;
	localparam int GRID_HEIGHT_DEF = 64;

	localparam int ACTION_W = 2;
	localparam int COORD_W  = 6;
	localparam int CODE_W   = 2;
	localparam int COUNT_W  = 8;
	localparam int CFG_W    = 8;

	typedef enum logic [ACTION_W-1:0] {
		ACT_WRITE  = 2'd0,
		ACT_READ   = 2'd1,
		ACT_RUN    = 2'd2,
		ACT_UNUSED = 2'd3
	} gbcd_action_t;

	typedef enum logic {
		REG_PASS_COUNT   = 1'b0,
		REG_BLOCKED_CODE = 1'b1
	} gbcd_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} gbcd_state_t;

	typedef struct packed {
		logic item_accept;
		logic scan_start;
		logic done_load;
	} gbcd_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic stage_free;
	} gbcd_sts_t;

endpackage

// ===== src/gbcd_ctrl.sv =====
module gbcd_ctrl
	import gbcd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  gbcd_action_t       action,
	input  logic [COUNT_W-1:0] pass_count,
	input  gbcd_sts_t          sts,
	output logic               in_ready,
	output gbcd_cmd_t          cmd
);

	gbcd_state_t        state_q;
	gbcd_state_t        state_next;
	logic [COUNT_W-1:0] passes_left_q;
	logic               accept;
	logic               run_accept;
	logic               last_pass;

	assign in_ready   = (state_q == ST_IDLE) && sts.stage_free;
	assign accept     = in_valid && in_ready;
	assign run_accept = accept && (action == ACT_RUN);
	assign last_pass  = (passes_left_q == COUNT_W'(1));

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (run_accept) begin
					state_next = (pass_count == '0) ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_done && last_pass) begin
					state_next = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.stage_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.item_accept = accept && (action != ACT_RUN);
				cmd.scan_start  = run_accept && (pass_count != '0);
			end
			ST_SCAN: begin
				cmd.scan_start = sts.scan_done && !last_pass;
			end
			ST_DONE: begin
				cmd.done_load = sts.stage_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			passes_left_q <= '0;
		end else begin
			state_q <= state_next;
			if (run_accept) begin
				passes_left_q <= pass_count;
			end else if (state_q == ST_SCAN && sts.scan_done) begin
				passes_left_q <= passes_left_q - COUNT_W'(1);
			end
		end
	end

endmodule

// ===== src/gbcd_datapath.sv =====
module gbcd_datapath
	import gbcd_pkg::*;
#(
	parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gbcd_cmd_t          cmd,
	input  gbcd_action_t       action,
	input  logic [COORD_W-1:0] row,
	input  logic [COORD_W-1:0] col,
	input  logic [CODE_W-1:0]  cell_value,
	input  logic [CODE_W-1:0]  blocked_code,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [CODE_W-1:0]  read_value,
	output logic               run_done,
	output gbcd_sts_t          sts
);

	localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW     = $clog2(CELLS);
	localparam int JW     = $clog2(CELLS + GRID_WIDTH);
	localparam int CW     = $clog2(GRID_WIDTH);
	localparam int LINE_N = 2 * GRID_WIDTH + 1;

	logic [CODE_W-1:0] mem_q [CELLS];
	logic [CODE_W-1:0] rd_q;

	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [CODE_W-1:0] mem_wd;
	logic              mem_re;
	logic [AW-1:0]     mem_ra;

	logic          in_grid;
	logic [AW-1:0] item_addr;

	logic          issue_q;
	logic [JW-1:0] rd_cnt_q;
	logic          v_s1;
	logic          ing_s1;
	logic [JW-1:0] j_s1;
	logic [LINE_N-1:0] line_q;
	logic [AW-1:0] ci_q;
	logic [CW-1:0] ccol_q;
	logic          c_s2;
	logic [AW-1:0] i_s2;
	logic [CW-1:0] col_s2;
	logic          mark;
	logic          scan_rd_ok;

	logic          pv_s1;
	logic          prd_s1;
	logic          pdone_s1;
	logic          p_adv;
	logic          out_valid_q;
	logic [CODE_W-1:0] read_value_q;
	logic          run_done_q;

	assign in_grid   = (32'(row) < GRID_HEIGHT) && (32'(col) < GRID_WIDTH);
	assign item_addr = AW'(32'(row) * 32'(GRID_WIDTH) + 32'(col));

	assign scan_rd_ok = (rd_cnt_q < JW'(CELLS));

	assign mark = (line_q[0])
		|| (line_q[2*GRID_WIDTH])
		|| (line_q[GRID_WIDTH+1] && (col_s2 != '0))
		|| (line_q[GRID_WIDTH-1] && (col_s2 != CW'(GRID_WIDTH - 1)));

	always_comb begin
		mem_we = 1'b0;
		mem_wa = item_addr;
		mem_wd = cell_value;
		mem_re = 1'b0;
		mem_ra = item_addr;
		if (c_s2 && mark) begin
			mem_we = 1'b1;
			mem_wa = i_s2;
			mem_wd = blocked_code;
		end else if (cmd.item_accept && action == ACT_WRITE && in_grid) begin
			mem_we = 1'b1;
		end
		if (issue_q) begin
			mem_re = scan_rd_ok;
			mem_ra = rd_cnt_q[AW-1:0];
		end else if (cmd.item_accept && action == ACT_READ) begin
			mem_re = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem_q[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q  <= 1'b0;
			rd_cnt_q <= '0;
			v_s1     <= 1'b0;
			c_s2     <= 1'b0;
			line_q   <= '0;
			ci_q     <= '0;
			ccol_q   <= '0;
		end else if (cmd.scan_start) begin
			issue_q  <= 1'b1;
			rd_cnt_q <= '0;
			v_s1     <= 1'b0;
			c_s2     <= 1'b0;
			line_q   <= '0;
			ci_q     <= '0;
			ccol_q   <= '0;
		end else begin
			v_s1 <= issue_q;
			if (issue_q) begin
				rd_cnt_q <= rd_cnt_q + JW'(1);
				if (rd_cnt_q == JW'(CELLS + GRID_WIDTH - 1)) begin
					issue_q <= 1'b0;
				end
			end
			c_s2 <= v_s1 && (j_s1 >= JW'(GRID_WIDTH));
			if (v_s1) begin
				line_q <= {line_q[LINE_N-2:0], ing_s1 && (rd_q == blocked_code)};
				if (j_s1 >= JW'(GRID_WIDTH)) begin
					ci_q   <= ci_q + AW'(1);
					ccol_q <= (ccol_q == CW'(GRID_WIDTH - 1)) ? '0 : ccol_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		ing_s1 <= scan_rd_ok;
		j_s1   <= rd_cnt_q;
		i_s2   <= ci_q;
		col_s2 <= ccol_q;
	end

	assign sts.scan_done  = c_s2 && (i_s2 == AW'(CELLS - 1));
	assign p_adv          = !out_valid_q || out_ready;
	assign sts.stage_free = !pv_s1 || p_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.item_accept || cmd.done_load) begin
				pv_s1 <= 1'b1;
			end else if (p_adv) begin
				pv_s1 <= 1'b0;
			end
			if (p_adv) begin
				out_valid_q <= pv_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.item_accept || cmd.done_load) begin
			prd_s1   <= cmd.item_accept && (action == ACT_READ) && in_grid;
			pdone_s1 <= cmd.done_load;
		end
		if (p_adv && pv_s1) begin
			read_value_q <= prd_s1 ? rd_q : '0;
			run_done_q   <= pdone_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign run_done   = run_done_q;

endmodule

// ===== src/grid_blocked_cell_dilation_core.sv =====
// Write, read and unused items are taken one per cycle while the result stage is free; each result
// passes through the pv_s1 stage and then the output register.
// A run item makes pass_count raster scans of the cell memory, one per pass, through its single read port.
// No item is accepted while a run is in progress.
// Reset clears control state and sets pass_count and blocked_code to 1; cell memory is not cleared.
module grid_blocked_cell_dilation_core
	import gbcd_pkg::*;
#(
	parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// action[1:0], row[7:2], col[13:8], cell_value[15:14]
	input  logic [15:0]      s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// read_value[1:0], zero fill above
	output logic [7:0]       m_tdata,
	// run_done[0]
	output logic             m_tuser,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [COUNT_W-1:0] pass_count_q;
	logic [CODE_W-1:0]  blocked_code_q;
	gbcd_action_t       action;
	logic [CODE_W-1:0]  read_value;
	gbcd_cmd_t          cmd;
	gbcd_sts_t          sts;

	assign action = gbcd_action_t'(s_tdata[1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_count_q   <= COUNT_W'(1);
			blocked_code_q <= CODE_W'(1);
		end else if (cfg_we) begin
			unique case (gbcd_reg_t'(cfg_index))
				REG_PASS_COUNT:   pass_count_q   <= cfg_data[COUNT_W-1:0];
				REG_BLOCKED_CODE: blocked_code_q <= cfg_data[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	gbcd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.action     (action),
		.pass_count (pass_count_q),
		.sts        (sts),
		.in_ready   (s_tready),
		.cmd        (cmd)
	);

	gbcd_datapath #(
		.GRID_WIDTH  (GRID_WIDTH),
		.GRID_HEIGHT (GRID_HEIGHT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.action       (action),
		.row          (s_tdata[7:2]),
		.col          (s_tdata[13:8]),
		.cell_value   (s_tdata[15:14]),
		.blocked_code (blocked_code_q),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.read_value   (read_value),
		.run_done     (m_tuser),
		.sts          (sts)
	);

	assign m_tdata = {6'd0, read_value};

endmodule

// ===== src/gbcd_checker.sv =====
module gbcd_checker
	import gbcd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Result item dropped while stalled.");

	a_done_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 8'd0)
		else $error("Run result carries read data.");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:2] == 6'd0)
		else $error("Result padding bits are not zero.");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tdata[1:0] == ACT_RUN) |=> !s_tready)
		else $error("Input accepted right after a run item.");

endmodule

bind grid_blocked_cell_dilation_core gbcd_checker u_gbcd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== sim/grid_blocked_cell_dilation_core_tb.sv =====
`timescale 1ns / 1ps

module grid_blocked_cell_dilation_core_tb;
	import gbcd_pkg::*;

	localparam int GRID_W = GRID_WIDTH_DEF;
	localparam int GRID_H = GRID_HEIGHT_DEF;
	localparam int GRID_CELLS = GRID_W * GRID_H;
	localparam int WATCHDOG_LIMIT = 4_500_000;
	localparam int LONG_HOLD = 400;
	localparam int PHASES = 6;

	typedef struct packed {
		logic [CODE_W-1:0]  cell_value;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		gbcd_action_t       action;
	} grid_item_t;

	typedef struct {
		logic [CODE_W-1:0] read_value;
		logic              run_done;
	} grid_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [15:0]      s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [7:0]       m_tdata;
	logic             m_tuser;
	logic             cfg_we = 1'b0;
	logic             cfg_index = REG_PASS_COUNT;
	logic [CFG_W-1:0] cfg_data = '0;

	grid_item_t   outgoing_items [$];
	grid_result_t expected_results [$];

	logic [CODE_W-1:0]  cell_model [0:GRID_CELLS-1];
	logic [COUNT_W-1:0] passes_model = 8'd1;
	logic [CODE_W-1:0]  blocked_model = 2'd1;

	logic [7:0] pass_plan [0:PHASES-1] = '{8'd0, 8'd2, 8'd1, 8'd3, 8'd255, 8'd1};
	logic [1:0] code_plan [0:PHASES-1] = '{2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1};

	int failures = 0;
	int results_seen = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_left = 0;
	int rx_cycle = 0;
	int idle_cycles = 0;
	int last_row = 0;
	int last_col = 0;
	bit long_hold_go = 1'b0;
	bit long_hold_done = 1'b0;

	grid_blocked_cell_dilation_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Every cell with a neighbor holding the blocked code at the start of a pass takes
	// that code. A pass that changes nothing means the grid has settled.
	function automatic void dilate_model(logic [COUNT_W-1:0] passes);
		logic [CODE_W-1:0] snap [0:GRID_CELLS-1];
		int changed;
		bit hit;
		for (int k = 0; k < passes; k++) begin
			snap = cell_model;
			changed = 0;
			for (int r = 0; r < GRID_H; r++) begin
				for (int c = 0; c < GRID_W; c++) begin
					hit = (r > 0 && snap[(r - 1) * GRID_W + c] == blocked_model) ||
						(r < GRID_H - 1 && snap[(r + 1) * GRID_W + c] == blocked_model) ||
						(c > 0 && snap[r * GRID_W + c - 1] == blocked_model) ||
						(c < GRID_W - 1 && snap[r * GRID_W + c + 1] == blocked_model);
					if (hit && snap[r * GRID_W + c] != blocked_model) begin
						cell_model[r * GRID_W + c] = blocked_model;
						changed++;
					end
				end
			end
			if (changed == 0) begin
				break;
			end
		end
	endfunction

	function automatic void predict_grid_item(grid_item_t it);
		grid_result_t res;
		int at;
		res.read_value = '0;
		res.run_done = 1'b0;
		at = it.row * GRID_W + it.col;
		case (it.action)
			ACT_WRITE: begin
				cell_model[at] = it.cell_value;
			end
			ACT_READ: begin
				res.read_value = cell_model[at];
			end
			ACT_RUN: begin
				dilate_model(passes_model);
				res.run_done = 1'b1;
			end
			default: begin
			end
		endcase
		expected_results.push_back(res);
	endfunction

	function automatic void queue_item(gbcd_action_t act, int row, int col, int value);
		grid_item_t it;
		it.action = act;
		it.row = row[COORD_W-1:0];
		it.col = col[COORD_W-1:0];
		it.cell_value = value[CODE_W-1:0];
		outgoing_items.push_back(it);
	endfunction

	// Sparse seeds of the blocked code over a background of the other codes.
	function automatic void queue_grid_fill();
		logic [CODE_W-1:0] value;
		for (int r = 0; r < GRID_H; r++) begin
			for (int c = 0; c < GRID_W; c++) begin
				if ($urandom_range(63, 0) == 0) begin
					value = blocked_model;
				end else begin
					value = blocked_model + CODE_W'($urandom_range(3, 1));
				end
				queue_item(ACT_WRITE, r, c, value);
			end
		end
	endfunction

	function automatic void queue_random_items(int count, bit with_runs);
		int sel;
		int row;
		int col;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(99, 0);
			row = $urandom_range(63, 0);
			col = $urandom_range(63, 0);
			if (sel < 45) begin
				queue_item(ACT_WRITE, row, col, $urandom_range(3, 0));
				last_row = row;
				last_col = col;
			end else if (sel < 70) begin
				queue_item(ACT_READ, last_row, last_col, $urandom_range(3, 0));
			end else if (sel < 94 || (sel >= 98 && !with_runs)) begin
				queue_item(ACT_READ, row, col, $urandom_range(3, 0));
			end else if (sel < 98) begin
				queue_item(ACT_UNUSED, row, col, $urandom_range(3, 0));
			end else begin
				queue_item(ACT_RUN, row, col, $urandom_range(3, 0));
			end
		end
	endfunction

	task automatic wait_for_drain();
		do begin
			@(negedge clk);
		end while (outgoing_items.size() != 0 || expected_results.size() != 0 || s_tvalid);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(gbcd_reg_t index, logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == REG_PASS_COUNT) begin
			passes_model = value;
		end else begin
			blocked_model = value[CODE_W-1:0];
		end
	endtask

	task automatic log_failure(string msg);
		failures++;
		if (failures <= 10) begin
			$display("%t: %s", $realtime, msg);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				predict_grid_item(outgoing_items.pop_front());
			end
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (outgoing_items.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= outgoing_items[0];
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(48, 1);
					gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		grid_result_t exp;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					log_failure($sformatf("result %0d with nothing expected: tdata %h tuser %b",
						results_seen, m_tdata, m_tuser));
				end else begin
					exp = expected_results.pop_front();
					if (m_tdata !== {6'd0, exp.read_value} || m_tuser !== exp.run_done) begin
						log_failure($sformatf({"result %0d: expected read_value %0d run_done %0d,",
							" got tdata %h tuser %b"}, results_seen, exp.read_value,
							exp.run_done, m_tdata, m_tuser));
					end
				end
			end
			rx_cycle++;
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (long_hold_go && !long_hold_done) begin
				long_hold_done = 1'b1;
				stall_left = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else begin
				case ((rx_cycle >> 8) % 4)
					0: m_tready <= 1'b1;
					1: m_tready <= $urandom_range(1, 0);
					2: m_tready <= (rx_cycle % 4 == 0);
					default: m_tready <= ($urandom_range(3, 0) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("grid_blocked_cell_dilation_core: mismatch");
			$finish;
		end else begin
			idle_cycles++;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The cell memory is not cleared by reset, so every cell is written before use.
		long_hold_go = 1'b1;
		queue_grid_fill();
		queue_item(ACT_WRITE, 0, 0, 1);
		queue_item(ACT_WRITE, 0, 63, 1);
		queue_item(ACT_WRITE, 63, 0, 1);
		queue_item(ACT_WRITE, 63, 63, 1);
		queue_item(ACT_WRITE, 32, 32, 1);
		queue_item(ACT_WRITE, 10, 10, 3);
		queue_item(ACT_READ, 10, 10, 3);
		queue_item(ACT_READ, 63, 63, 0);
		queue_item(ACT_UNUSED, 63, 63, 3);
		queue_item(ACT_READ, 0, 0, 2);
		queue_item(ACT_RUN, 63, 63, 3);
		queue_item(ACT_READ, 0, 1, 0);
		queue_item(ACT_READ, 1, 0, 0);
		queue_item(ACT_READ, 62, 63, 0);
		queue_item(ACT_READ, 63, 62, 0);
		queue_item(ACT_READ, 0, 62, 0);
		queue_item(ACT_READ, 1, 63, 0);
		queue_item(ACT_READ, 62, 0, 0);
		queue_item(ACT_READ, 63, 1, 0);
		queue_item(ACT_READ, 31, 32, 0);
		queue_item(ACT_READ, 33, 32, 0);
		queue_item(ACT_READ, 32, 31, 0);
		queue_item(ACT_READ, 32, 33, 0);
		queue_item(ACT_READ, 32, 32, 0);

		for (int p = 0; p < PHASES; p++) begin
			wait_for_drain();
			write_reg(REG_PASS_COUNT, pass_plan[p]);
			write_reg(REG_BLOCKED_CODE, CFG_W'(code_plan[p]));
			@(negedge clk);
			if (pass_plan[p] == 8'd255) begin
				queue_item(ACT_RUN, 0, 0, 0);
				queue_random_items(120, 1'b0);
			end else begin
				queue_random_items(170, 1'b1);
			end
		end

		wait_for_drain();
		repeat (16) @(posedge clk);
		failures += expected_results.size();
		if (failures == 0) begin
			$display("grid_blocked_cell_dilation_core: match");
		end else begin
			$display("grid_blocked_cell_dilation_core: mismatch");
		end
		$finish;
	end

endmodule
